>>> sv/cfpr_pkg.sv
// Shared types, constants and the CRC byte update for the framed packet receiver.
`default_nettype none

package cfpr_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [7:0] SYNC_FIRST_RST    = 8'd170;
    localparam logic [7:0] SYNC_SECOND_RST   = 8'd85;
    localparam logic [5:0] PAYLOAD_LIMIT_RST = 6'd32;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Controller states: parse phases, then the drain of an accepted frame
    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_TYPE,
        ST_LEN,
        ST_SEQ,
        ST_DATA,
        ST_CRCLO,
        ST_CRCHI,
        ST_READ,
        ST_SHOW,
        ST_EMPTY
    } cfpr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_type;
        logic load_length;
        logic load_sequence;
        logic store_data;
        logic load_crc_low;
        logic mark_end;
        logic drain_clear;
        logic drain_read;
        logic drain_next;
        logic show_empty;
    } cfpr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic first_hit;
        logic second_hit;
        logic length_over;
        logic length_zero;
        logic fill_done;
        logic crc_match;
        logic drain_last;
        logic resume_sync2;
    } cfpr_status_t;

    // One byte through the MSB-first CRC, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

>>> sv/cfpr_ctrl.sv
// Controller state machine: frame parse phases and result drain sequencing.
`default_nettype none

module cfpr_ctrl
    import cfpr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire cfpr_status_t status,
    output cfpr_cmd_t         cmd
);

    cfpr_state_t state_reg;
    cfpr_state_t state_next;
    logic        accept;
    cfpr_state_t resume_state;

    assign accept = s_valid && s_ready;

    // Where to go once a frame is over
    always_comb begin
        resume_state = status.resume_sync2 ? ST_SYNC2 : ST_SYNC1;
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SYNC1;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SYNC1: begin
                if (accept && status.first_hit) state_next = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (accept) begin
                    if (status.second_hit) begin
                        state_next = ST_TYPE;
                    end else if (!status.first_hit) begin
                        state_next = ST_SYNC1;
                    end
                end
            end
            ST_TYPE: begin
                if (accept) state_next = ST_LEN;
            end
            ST_LEN: begin
                if (accept) begin
                    if (status.length_over) begin
                        state_next = status.first_hit ? ST_SYNC2 : ST_SYNC1;
                    end else begin
                        state_next = ST_SEQ;
                    end
                end
            end
            ST_SEQ: begin
                if (accept) state_next = status.length_zero ? ST_CRCLO : ST_DATA;
            end
            ST_DATA: begin
                if (accept && status.fill_done) state_next = ST_CRCLO;
            end
            ST_CRCLO: begin
                if (accept) state_next = ST_CRCHI;
            end
            ST_CRCHI: begin
                if (accept) begin
                    if (!status.crc_match) begin
                        state_next = status.first_hit ? ST_SYNC2 : ST_SYNC1;
                    end else if (status.length_zero) begin
                        state_next = ST_EMPTY;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (m_ready) state_next = status.drain_last ? resume_state : ST_READ;
            end
            ST_EMPTY: begin
                if (m_ready) state_next = resume_state;
            end
            default: begin
                state_next = ST_SYNC1;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_SYNC1, ST_SYNC2: begin
                s_ready = 1'b1;
            end
            ST_TYPE: begin
                s_ready       = 1'b1;
                cmd.load_type = accept;
            end
            ST_LEN: begin
                s_ready         = 1'b1;
                cmd.load_length = accept;
            end
            ST_SEQ: begin
                s_ready           = 1'b1;
                cmd.load_sequence = accept;
            end
            ST_DATA: begin
                s_ready        = 1'b1;
                cmd.store_data = accept;
            end
            ST_CRCLO: begin
                s_ready          = 1'b1;
                cmd.load_crc_low = accept;
            end
            ST_CRCHI: begin
                s_ready         = 1'b1;
                cmd.mark_end    = accept;
                cmd.drain_clear = accept;
            end
            ST_READ: begin
                cmd.drain_read = 1'b1;
            end
            ST_SHOW: begin
                m_valid        = 1'b1;
                cmd.drain_next = m_ready;
            end
            ST_EMPTY: begin
                m_valid        = 1'b1;
                cmd.show_empty = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/cfpr_datapath.sv
// Datapath: config registers, header and CRC registers, payload memory and result word.
`default_nettype none

module cfpr_datapath
    import cfpr_pkg::*;
#(
    parameter int PAYLOAD_CAPACITY = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_wdata,
    input  wire logic [7:0]   s_rx_byte,
    input  wire cfpr_cmd_t    cmd,
    output cfpr_status_t      status,
    output logic [7:0]        m_frame_type,
    output logic [7:0]        m_frame_sequence,
    output logic [5:0]        m_frame_length,
    output logic [7:0]        m_data_byte,
    output logic              m_has_data,
    output logic              m_last
);

    localparam int         AW  = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
    localparam logic [6:0] CAP = 7'(PAYLOAD_CAPACITY);

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [5:0]  payload_limit_reg;
    logic [7:0]  held_type_reg;
    logic [7:0]  held_sequence_reg;
    logic [5:0]  held_length_reg;
    logic [5:0]  fill_reg;
    logic [15:0] crc_reg;
    logic [7:0]  crc_low_reg;
    logic        resume_reg;
    logic [5:0]  rd_ptr_reg;
    logic [7:0]  rd_data_reg;
    logic [7:0]  mem [PAYLOAD_CAPACITY];

    logic [6:0]  limit_eff;
    logic [6:0]  fill_sum;
    logic [6:0]  rd_sum;
    logic [15:0] crc_seed;
    logic [15:0] crc_new;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg    <= SYNC_FIRST_RST;
            sync_second_reg   <= SYNC_SECOND_RST;
            payload_limit_reg <= PAYLOAD_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SYNC_FIRST:    sync_first_reg    <= cfg_wdata;
                REG_SYNC_SECOND:   sync_second_reg   <= cfg_wdata;
                REG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_wdata[5:0];
                default:           ;
            endcase
        end
    end

    // Limit saturated to the memory depth
    assign limit_eff = ({1'b0, payload_limit_reg} > CAP) ? CAP : {1'b0, payload_limit_reg};

    // CRC update; the type word restarts from the init value
    assign crc_seed = cmd.load_type ? CRC_INIT : crc_reg;
    assign crc_new  = crc_byte(crc_seed, s_rx_byte);

    assign fill_sum = {1'b0, fill_reg} + 7'd1;
    assign rd_sum   = {1'b0, rd_ptr_reg} + 7'd1;

    // Header, CRC, fill and read pointer registers
    always_ff @(posedge aclk) begin
        if (cmd.load_type) begin
            held_type_reg <= s_rx_byte;
        end
        if (cmd.load_type || cmd.load_length || cmd.load_sequence || cmd.store_data) begin
            crc_reg <= crc_new;
        end
        if (cmd.load_length) begin
            held_length_reg <= s_rx_byte[5:0];
        end
        if (cmd.load_sequence) begin
            held_sequence_reg <= s_rx_byte;
            fill_reg          <= '0;
        end else if (cmd.store_data) begin
            fill_reg <= fill_sum[5:0];
        end
        if (cmd.load_crc_low) begin
            crc_low_reg <= s_rx_byte;
        end
        if (cmd.drain_clear) begin
            rd_ptr_reg <= '0;
        end else if (cmd.drain_next) begin
            rd_ptr_reg <= rd_sum[5:0];
        end
    end

    // Sync decision after a frame ends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resume_reg <= 1'b0;
        end else if (cmd.mark_end) begin
            resume_reg <= status.first_hit;
        end
    end

    // Payload memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.store_data && ({1'b0, fill_reg} < CAP)) begin
            mem[fill_reg[AW-1:0]] <= s_rx_byte;
        end
        if (cmd.drain_read) begin
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // Status to the controller
    always_comb begin
        status.first_hit    = (s_rx_byte == sync_first_reg);
        status.second_hit   = (s_rx_byte == sync_second_reg);
        status.length_over  = ({1'b0, s_rx_byte} > {2'b00, limit_eff});
        status.length_zero  = (held_length_reg == 6'd0);
        status.fill_done    = (fill_sum >= {1'b0, held_length_reg});
        status.crc_match    = ({s_rx_byte, crc_low_reg} == crc_reg);
        status.drain_last   = (rd_sum == {1'b0, held_length_reg});
        status.resume_sync2 = resume_reg;
    end

    // Result word
    always_comb begin
        m_frame_type     = held_type_reg;
        m_frame_sequence = held_sequence_reg;
        m_frame_length   = cmd.show_empty ? 6'd0 : held_length_reg;
        m_data_byte      = cmd.show_empty ? 8'd0 : rd_data_reg;
        m_has_data       = !cmd.show_empty;
        m_last           = cmd.show_empty || status.drain_last;
    end

endmodule

`default_nettype wire

>>> sv/crc16_framed_packet_receiver_unit.sv
// Parse phases take one received word per cycle; the block is ready in every parse phase.
// After the CRC high word matches, a read state registers a payload word from memory and a
// show state then offers it; this repeats for each word, and the show state holds while the
// output stalls. An empty frame gives its one result in the next cycle. No input is taken
// while a frame drains. Reset (aresetn low, synchronous) returns to the first-sync
// search and restores the config defaults; the payload memory is not cleared.
`default_nettype none

module crc16_framed_packet_receiver_unit
    import cfpr_pkg::*;
#(
    parameter int PAYLOAD_CAPACITY = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_frame_type,
    output logic [7:0]      m_frame_sequence,
    output logic [5:0]      m_frame_length,
    output logic [7:0]      m_data_byte,
    output logic            m_has_data,
    output logic            m_last
);

    cfpr_cmd_t    cmd;
    cfpr_status_t status;

    cfpr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cfpr_datapath #(
        .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .status           (status),
        .m_frame_type     (m_frame_type),
        .m_frame_sequence (m_frame_sequence),
        .m_frame_length   (m_frame_length),
        .m_data_byte      (m_data_byte),
        .m_has_data       (m_has_data),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire

>>> sv/cfpr_checker.sv
// Port-level checker for the framed packet receiver, bound to the top level.
`default_nettype none

module cfpr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_frame_type,
    input wire logic [5:0] m_frame_length,
    input wire logic [7:0] m_data_byte,
    input wire logic       m_has_data,
    input wire logic       m_last
);

    // Input side is closed while results are offered
    a_no_rx_during_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result word is offered");

    // A non-final result is followed by more of the same frame
    a_frame_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !s_ready)
        else $error("frame drain ended before its last word");

    // Empty result shape
    a_empty_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_data) |-> (m_last && m_frame_length == 6'd0 && m_data_byte == 8'd0))
        else $error("malformed empty result");

    // Data results carry a nonzero length
    a_data_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_data) |-> (m_frame_length != 6'd0))
        else $error("data word with zero frame length");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data_byte) && $stable(m_frame_type)))
        else $error("stalled result word changed");

endmodule

bind crc16_framed_packet_receiver_unit cfpr_checker u_cfpr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_type   (m_frame_type),
    .m_frame_length (m_frame_length),
    .m_data_byte    (m_data_byte),
    .m_has_data     (m_has_data),
    .m_last         (m_last)
);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the CRC-16 framed packet receiver: directed and random byte streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cfpr_pkg::*;

    localparam int CAPACITY = 32;

    // One result word as the block presents it
    typedef struct {
        logic [7:0] frame_type;
        logic [7:0] frame_sequence;
        logic [5:0] frame_length;
        logic [7:0] data_byte;
        logic       has_data;
        logic       last;
    } out_word_t;

    // Frame parser model plus the queue of result words it predicts
    class packet_tracker;
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [5:0]  payload_limit;
        cfpr_state_t phase;
        logic [7:0]  held_type;
        logic [7:0]  held_sequence;
        logic [7:0]  crc_low;
        logic [5:0]  held_length;
        logic [5:0]  fill;
        logic [15:0] crc;
        logic [7:0]  payload [CAPACITY];
        out_word_t   awaited[$];
        int          errors;
        int          words_taken;
        int          words_checked;
        int          frames_delivered;

        function new();
            errors = 0;
            words_taken = 0;
            words_checked = 0;
            frames_delivered = 0;
            sync_first = SYNC_FIRST_RST;
            sync_second = SYNC_SECOND_RST;
            payload_limit = PAYLOAD_LIMIT_RST;
            phase = ST_SYNC1;
            held_type = '0;
            held_sequence = '0;
            held_length = '0;
            fill = '0;
            crc = CRC_INIT;
            crc_low = '0;
        endfunction

        function void write_register(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_SYNC_FIRST:    sync_first = value;
                REG_SYNC_SECOND:   sync_second = value;
                REG_PAYLOAD_LIMIT: payload_limit = value[5:0];
                default: ;
            endcase
        endfunction

        // Limit register saturates at the store size
        function int length_cap();
            return (payload_limit > CAPACITY) ? CAPACITY : int'(payload_limit);
        endfunction

        // MSB-first CRC-16, poly 0x1021, one byte
        function logic [15:0] crc_update(logic [15:0] crc_in, logic [7:0] data);
            logic [15:0] c;
            c = crc_in ^ {data, 8'h00};
            repeat (8) c = {c[14:0], 1'b0} ^ (c[15] ? CRC_POLY : 16'h0000);
            return c;
        endfunction

        // Back to sync search; a first-sync word here already counts
        function void rearm(logic [7:0] b);
            phase = (b == sync_first) ? ST_SYNC2 : ST_SYNC1;
            fill = '0;
            crc = CRC_INIT;
            crc_low = '0;
        endfunction

        function void take_rx_word(logic [7:0] b);
            out_word_t w;
            words_taken++;
            case (phase)
                ST_SYNC1: begin
                    if (b == sync_first) phase = ST_SYNC2;
                end
                ST_SYNC2: begin
                    // second-sync match wins when both sync values are equal
                    if (b == sync_second) phase = ST_TYPE;
                    else if (b != sync_first) phase = ST_SYNC1;
                end
                ST_TYPE: begin
                    held_type = b;
                    crc = crc_update(CRC_INIT, b);
                    phase = ST_LEN;
                end
                ST_LEN: begin
                    crc = crc_update(crc, b);
                    held_length = b[5:0];
                    if (b > length_cap()) rearm(b);
                    else phase = ST_SEQ;
                end
                ST_SEQ: begin
                    held_sequence = b;
                    crc = crc_update(crc, b);
                    fill = '0;
                    phase = (held_length == 0) ? ST_CRCLO : ST_DATA;
                end
                ST_DATA: begin
                    if (fill < CAPACITY) payload[fill] = b;
                    fill = fill + 6'd1;
                    crc = crc_update(crc, b);
                    if (fill >= held_length) phase = ST_CRCLO;
                end
                ST_CRCLO: begin
                    crc_low = b;
                    phase = ST_CRCHI;
                end
                ST_CRCHI: begin
                    if ({b, crc_low} == crc) begin
                        frames_delivered++;
                        w.frame_type = held_type;
                        w.frame_sequence = held_sequence;
                        if (held_length == 0) begin
                            // empty frame: one marker word
                            w.frame_length = '0;
                            w.data_byte = '0;
                            w.has_data = 1'b0;
                            w.last = 1'b1;
                            awaited.push_back(w);
                        end else begin
                            for (int k = 0; k < held_length; k++) begin
                                w.frame_length = held_length;
                                w.data_byte = payload[k];
                                w.has_data = 1'b1;
                                w.last = (k + 1 == held_length);
                                awaited.push_back(w);
                            end
                        end
                    end
                    rearm(b);
                end
                default: phase = ST_SYNC1;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_out_word(out_word_t got);
            out_word_t want;
            words_checked++;
            if (awaited.size() == 0) begin
                $error("result word with nothing expected (type 0x%0h, data 0x%0h)",
                       got.frame_type, got.data_byte);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("frame_sequence", want.frame_sequence, got.frame_sequence);
            compare_field("frame_length", 8'(want.frame_length), 8'(got.frame_length));
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("has_data", 8'(want.has_data), 8'(got.has_data));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_frame_type;
    logic [7:0] m_frame_sequence;
    logic [5:0] m_frame_length;
    logic [7:0] m_data_byte;
    logic       m_has_data;
    logic       m_last;

    packet_tracker tracker = new();
    bit            no_idle = 1'b0;
    bit            hold_request = 1'b0;
    logic [7:0]    stream[$];
    logic [7:0]    payload_buf [CAPACITY];

    crc16_framed_packet_receiver_unit dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= 36);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        out_word_t w;
        if (aresetn && m_valid && m_ready) begin
            w.frame_type = m_frame_type;
            w.frame_sequence = m_frame_sequence;
            w.frame_length = m_frame_length;
            w.data_byte = m_data_byte;
            w.has_data = m_has_data;
            w.last = m_last;
            tracker.check_out_word(w);
        end
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one word, with random gaps ahead of it; called and returns at a falling edge
    task automatic send_word(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.take_rx_word(b);
        @(negedge aclk);
    endtask

    task automatic send_stream();
        foreach (stream[i]) send_word(stream[i]);
        stream.delete();
    endtask

    // Stop offering, drain every expected word, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                              input logic [7:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SYNC_FIRST;
        cfg_wdata <= first;
        @(negedge aclk);
        cfg_index <= REG_SYNC_SECOND;
        cfg_wdata <= second;
        @(negedge aclk);
        cfg_index <= REG_PAYLOAD_LIMIT;
        cfg_wdata <= limit;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.write_register(REG_SYNC_FIRST, first);
        tracker.write_register(REG_SYNC_SECOND, second);
        tracker.write_register(REG_PAYLOAD_LIMIT, limit);
    endtask

    function automatic void random_payload();
        foreach (payload_buf[i]) payload_buf[i] = 8'($urandom);
    endfunction

    function automatic logic [15:0] frame_check(logic [7:0] ft, logic [7:0] fl,
                                                logic [7:0] fs);
        logic [15:0] c;
        c = tracker.crc_update(CRC_INIT, ft);
        c = tracker.crc_update(c, fl);
        c = tracker.crc_update(c, fs);
        for (int i = 0; i < fl; i++) c = tracker.crc_update(c, payload_buf[i]);
        return c;
    endfunction

    // Whole frame from payload_buf; optionally without its first sync or with a bad check
    function automatic void push_frame(logic [7:0] ft, logic [7:0] fl, logic [7:0] fs,
                                       bit with_first, bit corrupt);
        logic [15:0] c;
        c = frame_check(ft, fl, fs);
        if (corrupt) c ^= 16'h0001 << $urandom_range(0, 15);
        if (with_first) stream.push_back(tracker.sync_first);
        stream.push_back(tracker.sync_second);
        stream.push_back(ft);
        stream.push_back(fl);
        stream.push_back(fs);
        for (int i = 0; i < fl; i++) stream.push_back(payload_buf[i]);
        stream.push_back(c[7:0]);
        stream.push_back(c[15:8]);
    endfunction

    // Header that is abandoned at its length word
    function automatic void push_oversize(logic [7:0] fl);
        stream.push_back(tracker.sync_first);
        stream.push_back(tracker.sync_second);
        stream.push_back(8'($urandom));
        stream.push_back(fl);
    endfunction

    // Mostly good frames with random content, the rest broken or noise
    function automatic void push_random_chunk();
        int         pick;
        int         cap;
        int         len;
        logic [7:0] nb;
        pick = $urandom_range(0, 99);
        cap = tracker.length_cap();
        len = ($urandom_range(0, 9) == 0) ? cap : $urandom_range(0, (cap < 6) ? cap : 6);
        random_payload();
        if (pick < 60) begin
            push_frame(8'($urandom), 8'(len), 8'($urandom), 1'b1, 1'b0);
        end else if (pick < 70) begin
            push_frame(8'($urandom), 8'(len), 8'($urandom), 1'b1, 1'b1);
        end else if (pick < 78) begin
            push_oversize(8'($urandom_range(cap + 1, 255)));
        end else if (pick < 86) begin
            // line noise that never looks like a first sync
            repeat ($urandom_range(1, 4)) begin
                nb = 8'($urandom);
                if (nb == tracker.sync_first) nb = ~nb;
                stream.push_back(nb);
            end
        end else if (pick < 93) begin
            // first sync followed by a word that is neither sync
            stream.push_back(tracker.sync_first);
            do begin
                nb = 8'($urandom);
            end while (nb == tracker.sync_first || nb == tracker.sync_second);
            stream.push_back(nb);
        end else begin
            repeat ($urandom_range(1, 3)) stream.push_back(tracker.sync_first);
            push_frame(8'($urandom), 8'(len), 8'($urandom), 1'b1, 1'b0);
        end
    endfunction

    task automatic run_random(input int n);
        int target;
        target = tracker.words_taken + n;
        while (tracker.words_taken < target) begin
            push_random_chunk();
            send_stream();
        end
    endtask

    initial begin
        logic [15:0] chk;
        logic [7:0]  hit_seq;
        logic [7:0]  hit_byte;
        bit          found;
        int          tries;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SYNC_FIRST;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: broken sync pair, then repeated first sync before an empty frame
        stream.push_back(tracker.sync_first);
        stream.push_back(8'h12);
        stream.push_back(tracker.sync_first);
        push_frame(8'h00, 8'd0, 8'hFF, 1'b1, 1'b0);
        // one-word frame at the field extremes
        payload_buf[0] = 8'hFF;
        push_frame(8'hFF, 8'd1, 8'h00, 1'b1, 1'b0);
        // bad check is dropped
        push_frame(8'h5A, 8'd0, 8'h01, 1'b1, 1'b1);
        // oversize length equal to the first sync: the next word completes a sync pair
        push_oversize(tracker.sync_first);
        push_frame(8'h01, 8'd0, 8'h02, 1'b0, 1'b0);
        // frame whose check high word is the first sync, followed straight by second sync
        found = 1'b0;
        hit_seq = '0;
        hit_byte = '0;
        tries = 0;
        while (!found && tries < 65536) begin
            payload_buf[0] = 8'(tries >> 8);
            chk = frame_check(8'h3C, 8'd1, 8'(tries));
            if (chk[15:8] == tracker.sync_first) begin
                found = 1'b1;
                hit_seq = 8'(tries);
                hit_byte = 8'(tries >> 8);
            end
            tries++;
        end
        payload_buf[0] = hit_byte;
        push_frame(8'h3C, 8'd1, hit_seq, 1'b1, 1'b0);
        push_frame(8'hC3, 8'd0, 8'h04, 1'b0, 1'b0);
        send_stream();

        // Defaults: a full-size frame, then random traffic
        foreach (payload_buf[i]) payload_buf[i] = i[0] ? 8'hFF : 8'h00;
        push_frame(8'h80, 8'd32, 8'h7F, 1'b1, 1'b0);
        send_stream();
        run_random(30);
        settle();

        // Zero limit: only empty frames get through
        set_config(8'h00, 8'hFF, 8'd0);
        run_random(25);
        settle();

        // Equal sync values, limit above the store size
        set_config(8'h7E, 8'h7E, 8'd63);
        random_payload();
        push_frame(8'($urandom), 8'd32, 8'($urandom), 1'b1, 1'b0);
        push_oversize(8'd33);
        send_stream();
        run_random(30);
        settle();

        set_config(8'hFF, 8'h00, 8'd5);
        run_random(25);
        settle();

        // Back to defaults, no idling on either side
        set_config(SYNC_FIRST_RST, SYNC_SECOND_RST, 8'(PAYLOAD_LIMIT_RST));
        no_idle = 1'b1;
        run_random(30);
        no_idle = 1'b0;
        settle();

        // Receiver holds off while long frames keep coming in
        hold_request = 1'b1;
        repeat (4) begin
            random_payload();
            push_frame(8'($urandom), 8'($urandom_range(8, 16)), 8'($urandom), 1'b1, 1'b0);
        end
        send_stream();
        run_random(20);
        settle();

        $display("Covered %0d received words, %0d delivered frames, %0d result words checked,",
                 tracker.words_taken, tracker.frames_delivered, tracker.words_checked);
        $display("over five register settings with bad checks, aborts and a long output stall.");
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
